// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files that check their own behavior.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every cycle outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/dtli_pkg.sv -----
// Package for the depth table linear interpolator.
// Types, widths and codes shared by the controller, datapath and top level.
`default_nettype none
package dtli_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = 6;
	localparam int LEN_W       = 7;
	localparam int DATA_W      = 32;
	localparam int WIDE_W      = DATA_W + 1;
	localparam int PROD_W      = 2 * WIDE_W;
	localparam int DCNT_W      = 6;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_QUERY = 2'd1,
		OP_CHECK = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_ORDER = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		A_ZERO,
		A_LAST,
		A_MID,
		A_LO,
		A_HI,
		A_CNT
	} addr_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_WR,
		S_QF,
		S_QF_CMP,
		S_QL_CMP,
		S_SRCH,
		S_SRCH_CMP,
		S_RLO,
		S_RHI,
		S_PREP,
		S_MUL,
		S_DIVI,
		S_DIV,
		S_FIN,
		S_CK0,
		S_CK1,
		S_CK_RD,
		S_CK_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic      load_in;
		logic      mem_wr;
		addr_sel_t addr_sel;
		logic      srch_init;
		logic      srch_step;
		logic      cap_lo;
		logic      cap_hi;
		logic      prep;
		logic      mul;
		logic      div_init;
		logic      div_step;
		logic      ck_init;
		logic      ck_prev;
		logic      ck_step;
		logic      res_rd;
		logic      res_v0;
		logic      res_fin;
		logic      st_range;
		logic      st_order;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic len_zero;
		logic len_short;
		logic wr_oob;
		logic rd_ge_q;
		logic rd_le_q;
		logic span_gt1;
		logic dd_le0;
		logic div_last;
		logic ck_bad;
		logic ck_last;
	} sts_t;

endpackage
`default_nettype wire

// ----- sv/dtli_if.sv -----
// Item channel interfaces for the depth table linear interpolator.
// Depends on dtli_pkg for field types.
`default_nettype none
interface dtli_in_if;
	import dtli_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	idx_t        entry_index;
	logic signed [DATA_W-1:0] entry_depth;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] query_depth;

	modport source (output valid, op, entry_index, entry_depth, entry_value, query_depth,
		input ready);
	modport sink (input valid, op, entry_index, entry_depth, entry_value, query_depth,
		output ready);
endinterface

interface dtli_out_if;
	import dtli_pkg::*;
	logic        valid;
	logic        ready;
	logic signed [DATA_W-1:0] result_value;
	logic [1:0]  status;
	idx_t        bad_index;

	modport source (output valid, result_value, status, bad_index, input ready);
	modport sink (input valid, result_value, status, bad_index, output ready);
endinterface
`default_nettype wire

// ----- sv/depth_table_linear_interpolator_unit.sv -----
// Top level of the depth table linear interpolator.
// Instantiates dtli_ctrl and dtli_dp; uses dtli_pkg, dtli_if and assert_macros.svh.
//
// One item at a time. Each search step needs a registered read of the single table
// port, and the quotient of an interpolating query comes from a one-bit-per-cycle
// divider. A check reads the entries in order and compares each with the one before
// it. The finished item sits in an output register, so the next item is taken while
// it waits. A table_len write resets every entry to minus one at once.
`default_nettype none
module depth_table_linear_interpolator_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	dtli_in_if.sink            in_ch,
	dtli_out_if.source         out_ch,
	input  wire logic          cfg_we,
	input  wire dtli_pkg::len_t cfg_wdata
);
	import dtli_pkg::*;

	cmd_t  cmd;
	sts_t  sts;
	word_t res_w;
	logic [1:0] st_w;
	idx_t  bad_w;

	dtli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sts       (sts),
		.cmd       (cmd),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready)
	);

	dtli_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_op      (in_ch.op),
		.in_index   (in_ch.entry_index),
		.in_depth   (in_ch.entry_depth),
		.in_value   (in_ch.entry_value),
		.in_query   (in_ch.query_depth),
		.out_result (res_w),
		.out_status (st_w),
		.out_bad    (bad_w)
	);

	assign out_ch.result_value = res_w;
	assign out_ch.status       = st_w;
	assign out_ch.bad_index    = bad_w;

`include "assert_macros.svh"

	`ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
	`ASSERT_IMPLIES(a_bad_only_on_order, out_ch.valid && (out_ch.status != ST_ORDER), out_ch.bad_index == '0)
	`ASSERT_IMPLIES(a_value_only_when_ok, out_ch.valid && (out_ch.result_value != '0), out_ch.status == ST_OK)

endmodule
`default_nettype wire

// ----- sv/dtli_dp.sv -----
// Datapath: table memories, search pointers, multiplier, serial divider, result regs.
// Driven by dtli_ctrl through cmd_t; uses dtli_pkg.
`default_nettype none
module dtli_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dtli_pkg::cmd_t    cmd,
	output dtli_pkg::sts_t         sts,
	input  wire logic              cfg_we,
	input  wire dtli_pkg::len_t    cfg_wdata,
	input  wire logic [1:0]        in_op,
	input  wire dtli_pkg::idx_t    in_index,
	input  wire dtli_pkg::word_t   in_depth,
	input  wire dtli_pkg::word_t   in_value,
	input  wire dtli_pkg::word_t   in_query,
	output dtli_pkg::word_t        out_result,
	output logic [1:0]             out_status,
	output dtli_pkg::idx_t         out_bad
);
	import dtli_pkg::*;

	word_t depth_mem [TABLE_DEPTH];
	word_t value_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	len_t  len_q;

	logic [1:0] op_q;
	idx_t  idx_q;
	word_t ed_q, ev_q, qd_q;

	word_t rd_draw_q, rd_vraw_q;
	logic  rd_ok_q;
	word_t rd_d, rd_v;

	idx_t  lo_q, hi_q, cnt_q, addr, mid;
	logic [IDX_W:0] mid_sum;
	len_t  len_m1;

	word_t d0_q, v0_q, d1_q, v1_q, pd_q, pv_q;
	logic signed [WIDE_W-1:0] dd_w, dq_w, dv_w;
	logic [WIDE_W-1:0] dd_q, dq_q, mag_q, rem_q, quo_q;
	logic neg_q;
	logic [PROD_W-1:0] prod_s1;
	logic [WIDE_W:0] trial, diff;
	logic [DCNT_W-1:0] dcnt_q;
	word_t fin_w;

	word_t res_q;
	status_t st_q;
	idx_t bad_q;

	// table length, saturated on write; valid bits cleared by config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			valid_q <= '0;
		end else if (cfg_we) begin
			len_q   <= (cfg_wdata > len_t'(TABLE_DEPTH)) ? len_t'(TABLE_DEPTH) : cfg_wdata;
			valid_q <= '0;
		end else if (cmd.mem_wr) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	always_comb begin
		mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
		mid     = mid_sum[IDX_W:1];
		len_m1  = len_q - len_t'(1);
		case (cmd.addr_sel)
			A_ZERO:  addr = '0;
			A_LAST:  addr = len_m1[IDX_W-1:0];
			A_MID:   addr = mid;
			A_LO:    addr = lo_q;
			A_HI:    addr = hi_q;
			A_CNT:   addr = cnt_q;
			default: addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			depth_mem[idx_q] <= ed_q;
			value_mem[idx_q] <= ev_q;
		end
		rd_draw_q <= depth_mem[addr];
		rd_vraw_q <= value_mem[addr];
		rd_ok_q   <= valid_q[addr];
	end

	assign rd_d = rd_ok_q ? rd_draw_q : '1;
	assign rd_v = rd_ok_q ? rd_vraw_q : '1;

	assign dd_w  = $signed({d1_q[DATA_W-1], d1_q}) - $signed({d0_q[DATA_W-1], d0_q});
	assign dq_w  = $signed({qd_q[DATA_W-1], qd_q}) - $signed({d0_q[DATA_W-1], d0_q});
	assign dv_w  = $signed({v1_q[DATA_W-1], v1_q}) - $signed({v0_q[DATA_W-1], v0_q});
	assign trial = {rem_q, quo_q[WIDE_W-1]};
	assign diff  = trial - {1'b0, dd_q};
	assign fin_w = neg_q ? (v0_q - quo_q[DATA_W-1:0]) : (v0_q + quo_q[DATA_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= in_op;
			idx_q <= in_index;
			ed_q  <= in_depth;
			ev_q  <= in_value;
			qd_q  <= in_query;
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= len_m1[IDX_W-1:0];
		end else if (cmd.srch_step) begin
			if ($signed(rd_d) <= $signed(qd_q)) lo_q <= mid;
			else hi_q <= mid;
		end
		if (cmd.cap_lo) begin
			d0_q <= rd_d;
			v0_q <= rd_v;
		end
		if (cmd.cap_hi) begin
			d1_q <= rd_d;
			v1_q <= rd_v;
		end
		if (cmd.prep) begin
			dd_q  <= dd_w;
			dq_q  <= dq_w[WIDE_W-1] ? '0 : dq_w;
			neg_q <= dv_w[WIDE_W-1];
			mag_q <= dv_w[WIDE_W-1] ? -dv_w : dv_w;
		end
		if (cmd.mul) prod_s1 <= {{WIDE_W{1'b0}}, dq_q} * {{WIDE_W{1'b0}}, mag_q};
		if (cmd.div_init) begin
			rem_q  <= prod_s1[PROD_W-1:WIDE_W];
			quo_q  <= prod_s1[WIDE_W-1:0];
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (!diff[WIDE_W]) rem_q <= diff[WIDE_W-1:0];
			else rem_q <= trial[WIDE_W-1:0];
			quo_q  <= {quo_q[WIDE_W-2:0], ~diff[WIDE_W]};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
		if (cmd.ck_init) cnt_q <= idx_t'(1);
		else if (cmd.ck_step) cnt_q <= cnt_q + idx_t'(1);
		if (cmd.ck_prev || cmd.ck_step) begin
			pd_q <= rd_d;
			pv_q <= rd_v;
		end
		if (cmd.load_in) begin
			res_q <= '0;
			st_q  <= ST_OK;
			bad_q <= '0;
		end else begin
			if (cmd.res_rd) res_q <= rd_v;
			else if (cmd.res_v0) res_q <= v0_q;
			else if (cmd.res_fin) res_q <= fin_w;
			if (cmd.st_range) st_q <= ST_RANGE;
			if (cmd.st_order) begin
				st_q  <= ST_ORDER;
				bad_q <= cnt_q;
			end
		end
		if (cmd.out_load) begin
			out_result <= res_q;
			out_status <= st_q;
			out_bad    <= bad_q;
		end
	end

	always_comb begin
		sts.op        = op_t'(op_q);
		sts.len_zero  = (len_q == '0);
		sts.len_short = (len_q < len_t'(2));
		sts.wr_oob    = ({1'b0, idx_q} >= len_q);
		sts.rd_ge_q   = ($signed(rd_d) >= $signed(qd_q));
		sts.rd_le_q   = ($signed(rd_d) <= $signed(qd_q));
		sts.span_gt1  = ((hi_q - lo_q) > idx_t'(1));
		sts.dd_le0    = dd_w[WIDE_W-1] || (dd_w == '0);
		sts.div_last  = (dcnt_q == DCNT_W'(WIDE_W - 1));
		sts.ck_bad    = ($signed(rd_d) <= $signed(pd_q)) || ($signed(rd_v) <= $signed(pv_q));
		sts.ck_last   = ({1'b0, cnt_q} == len_m1);
	end

endmodule
`default_nettype wire

// ----- sv/dtli_ctrl.sv -----
// Controller state machine sequencing writes, searches, division and checks.
// Talks to dtli_dp through cmd_t/sts_t; uses dtli_pkg.
`default_nettype none
module dtli_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire dtli_pkg::sts_t  sts,
	output dtli_pkg::cmd_t       cmd,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready
);
	import dtli_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.addr_sel = A_ZERO;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (sts.op)
					OP_WRITE: state_d = S_WR;
					OP_QUERY: state_d = sts.len_zero ? S_DONE : S_QF;
					OP_CHECK: state_d = sts.len_short ? S_DONE : S_CK0;
					default:  state_d = S_DONE;
				endcase
			end
			S_WR: begin
				if (sts.wr_oob) cmd.st_range = 1'b1;
				else cmd.mem_wr = 1'b1;
				state_d = S_DONE;
			end
			S_QF: begin
				cmd.addr_sel = A_ZERO;
				state_d = S_QF_CMP;
			end
			S_QF_CMP: begin
				if (sts.rd_ge_q) begin
					cmd.res_rd = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.addr_sel = A_LAST;
					state_d = S_QL_CMP;
				end
			end
			S_QL_CMP: begin
				if (sts.rd_le_q) begin
					cmd.res_rd = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.srch_init = 1'b1;
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (sts.span_gt1) begin
					cmd.addr_sel = A_MID;
					state_d = S_SRCH_CMP;
				end else begin
					cmd.addr_sel = A_LO;
					state_d = S_RLO;
				end
			end
			S_SRCH_CMP: begin
				cmd.srch_step = 1'b1;
				state_d = S_SRCH;
			end
			S_RLO: begin
				cmd.cap_lo = 1'b1;
				cmd.addr_sel = A_HI;
				state_d = S_RHI;
			end
			S_RHI: begin
				cmd.cap_hi = 1'b1;
				state_d = S_PREP;
			end
			S_PREP: begin
				if (sts.dd_le0) begin
					cmd.res_v0 = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.prep = 1'b1;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.res_fin = 1'b1;
				state_d = S_DONE;
			end
			S_CK0: begin
				cmd.addr_sel = A_ZERO;
				cmd.ck_init = 1'b1;
				state_d = S_CK1;
			end
			S_CK1: begin
				cmd.ck_prev = 1'b1;
				state_d = S_CK_RD;
			end
			S_CK_RD: begin
				cmd.addr_sel = A_CNT;
				state_d = S_CK_CMP;
			end
			S_CK_CMP: begin
				if (sts.ck_bad) begin
					cmd.st_order = 1'b1;
					state_d = S_DONE;
				end else if (sts.ck_last) begin
					state_d = S_DONE;
				end else begin
					cmd.ck_step = 1'b1;
					state_d = S_CK_RD;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire
